### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the ADC window sum block.
// Every macro samples on the rising edge of clk_i and is disabled while
// rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds in the same cycle.
`define ADSW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after an antecedent.
`define ADSW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/adsw_pkg.sv
// ----------------------------------------------------------------------------
// adsw_pkg
// Types and fixed constants of the ADC sliding window sum unit.
// ----------------------------------------------------------------------------
`default_nettype none

package adsw_pkg;

  // Width of the running sum and of the window length register.
  localparam int unsigned SumW = 18;
  localparam int unsigned CfgW = 7;

  // Window length after reset.
  localparam logic [CfgW-1:0] CfgLenReset = 7'd64;

  typedef logic [SumW-1:0] sum_t;
  typedef logic [CfgW-1:0] cfg_len_t;

endpackage

`default_nettype wire

### rtl/core/adsw_if.sv
// ----------------------------------------------------------------------------
// adsw_sample_if / adsw_result_if
// Valid/ready channels for ADC samples and for window sum results.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsw_sample_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface adsw_result_if;
  logic              valid;
  logic              ready;
  adsw_pkg::sum_t    window_sum;
  logic              window_full;

  modport source (output valid, output window_sum, output window_full, input ready);
  modport sink   (input valid, input window_sum, input window_full, output ready);
endinterface

`default_nettype wire

### rtl/core/adsw_ring_ram.sv
// ----------------------------------------------------------------------------
// adsw_ring_ram
// Sample ring buffer: one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module adsw_ring_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 12,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // A read and a write of the same entry at one edge return the old data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/adc_sliding_window_sum_unit.sv
// ----------------------------------------------------------------------------
// adc_sliding_window_sum_unit
// Running sum over the last window_length nonzero ADC samples.
// ----------------------------------------------------------------------------
// The unit takes one ADC sample per clock cycle while results are taken and
// returns, for every transaction on the sample channel, exactly one transaction
// on the result channel carrying the running window sum and the window full
// flag. An accepted sample is registered in the second stage and then in the
// output register, where its result becomes valid; a stall on the result side
// holds it in the second stage. The samples live in a single-port-write,
// single-port-read ring buffer memory: for a nonzero sample the oldest entry
// is read in the cycle it is accepted, and the subtract, add and write-back
// happen as it leaves the second stage. Zero samples are not stored and leave
// the sum unchanged. The window length register may only be written while no
// transaction is in flight; a value of zero acts as one and values above
// MAX_WINDOW act as MAX_WINDOW. The memory needs no clearing after reset,
// because the sum only subtracts entries that were written.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_sliding_window_sum_unit #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire adsw_pkg::cfg_len_t  cfg_wdata_i,
  adsw_sample_if.sink              in_if,
  adsw_result_if.source            out_if
);

  import adsw_pkg::*;

  localparam int unsigned IdxW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned LenW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CmpW = (IdxW + 1 > LenW) ? IdxW + 1 : LenW;

  // Configuration register.
  cfg_len_t cfg_len_q;

  // Front-end state: write pointer and full flag are settled at acceptance.
  logic [IdxW-1:0] widx_q, widx_d;
  logic            full_q, full_d;

  // Second stage: sample waiting for its ring buffer read data.
  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic [IdxW-1:0]        s1_pos_q;
  logic                   s1_wr_q;
  logic                   s1_sub_q;
  logic                   s1_full_q;
  logic                   s1_fwd_q;
  logic [SAMPLE_BITS-1:0] s1_fwd_data_q;

  // Running sum and output register.
  sum_t sum_q, sum_d;
  logic out_valid_q;
  sum_t out_sum_q;
  logic out_full_q;

  logic                   in_acc;
  logic                   s1_adv;
  logic                   nonzero;
  logic [LenW-1:0]        eff_len;
  logic [IdxW:0]          idx_after;
  logic                   wrap;
  logic                   fwd_hit;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SAMPLE_BITS-1:0] old_sample;

  // The second stage moves on when the output register is free or drained in the
  // same cycle; a new sample enters when the second stage is empty or moves on.
  assign s1_adv       = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready  = !s1_valid_q || s1_adv;
  assign in_acc       = in_if.valid && in_if.ready;
  assign nonzero      = |in_if.sample;

  // Zero acts as a window of one, and anything above the memory depth is
  // clamped to the depth.
  always_comb begin
    if (cfg_len_q == '0) begin
      eff_len = LenW'(1);
    end else if (32'(cfg_len_q) > MAX_WINDOW) begin
      eff_len = LenW'(MAX_WINDOW);
    end else begin
      eff_len = LenW'(cfg_len_q);
    end
  end

  // Pointer update. The wrap test is made even for a zero sample, so that a
  // shortened window takes effect on the next transaction.
  always_comb begin
    idx_after = nonzero ? ({1'b0, widx_q} + (IdxW+1)'(1)) : {1'b0, widx_q};
    wrap      = CmpW'(idx_after) >= CmpW'(eff_len);
    widx_d    = wrap ? '0 : idx_after[IdxW-1:0];
    full_d    = full_q || wrap;
  end

  // The previous sample is written back at the same edge at which this one
  // reads; with a one-entry window both hit the same entry, so the written
  // value is forwarded around the memory.
  assign fwd_hit = s1_adv && s1_wr_q && (s1_pos_q == widx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= CfgLenReset;
    end else if (cfg_we_i) begin
      cfg_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0;
      full_q <= 1'b0;
    end else if (in_acc) begin
      widx_q <= widx_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q   <= in_if.sample;
      s1_pos_q      <= widx_q;
      s1_wr_q       <= nonzero;
      s1_sub_q      <= nonzero && full_q;
      s1_full_q     <= full_d;
      s1_fwd_q      <= fwd_hit;
      s1_fwd_data_q <= s1_sample_q;
    end
  end

  adsw_ring_ram #(
    .DEPTH  (MAX_WINDOW),
    .DATA_W (SAMPLE_BITS),
    .ADDR_W (IdxW)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (s1_adv && s1_wr_q),
    .wr_addr_i (s1_pos_q),
    .wr_data_i (s1_sample_q),
    .rd_en_i   (in_acc && nonzero),
    .rd_addr_i (widx_q),
    .rd_data_o (rd_data)
  );

  // Read-modify-write: drop the oldest sample once the window is full, add the
  // new one. A zero sample adds nothing and subtracts nothing.
  always_comb begin
    old_sample = s1_fwd_q ? s1_fwd_data_q : rd_data;
    sum_d      = sum_q + SumW'(s1_sample_q) - (s1_sub_q ? SumW'(old_sample) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (s1_adv) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_sum_q  <= sum_d;
      out_full_q <= s1_full_q;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.window_sum  = out_sum_q;
  assign out_if.window_full = out_full_q;

endmodule

`default_nettype wire

### rtl/core/adsw_checker.sv
// ----------------------------------------------------------------------------
// adsw_checker
// Port-level checks of the ADC sliding window sum unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module adsw_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_i,
  input wire logic           out_valid_i,
  input wire logic           out_ready_i,
  input wire adsw_pkg::sum_t window_sum_i,
  input wire logic           window_full_i
);

  logic [2:0] pending_q;
  logic       seen_full_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Transactions accepted on the sample side and not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_full_q <= 1'b0;
    end else if (out_acc && window_full_i) begin
      seen_full_q <= 1'b1;
    end
  end

  // The unit holds at most two samples: one in the pipeline, one in the output.
  `ADSW_ASSERT(a_pending_bound, pending_q <= 3'd2, "more than two transactions in flight")

  // No result without a sample behind it.
  `ADSW_ASSERT(a_no_invented, !out_valid_i || (pending_q != 3'd0), "result without sample")

  // The full flag never drops once reported.
  `ADSW_ASSERT(a_full_sticky, !(out_valid_i && seen_full_q) || window_full_i,
               "window full flag dropped")

  // A stalled result keeps its payload.
  `ADSW_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
                    out_valid_i && $stable(window_sum_i) && $stable(window_full_i),
                    "stalled result changed")

endmodule

bind adc_sliding_window_sum_unit adsw_checker u_adsw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .window_sum_i  (out_if.window_sum),
  .window_full_i (out_if.window_full)
);

`default_nettype wire
